// ===== rtl/core/rbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types, register map and colour constants of the region boundary
// colouriser.
// ----------------------------------------------------------------------------
package rbc_pkg;

	// Default of the line buffer depth, in pixels.
	localparam int DEF_MAX_WIDTH = 2048;

	// Configuration port.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_COLOR_MODE       = 3'd0,
		REG_FRAME_WIDTH      = 3'd1,
		REG_FRAME_HEIGHT     = 3'd2,
		REG_BACKGROUND_COLOR = 3'd3,
		REG_BOUNDARY_COLOR   = 3'd4
	} reg_idx_t;

	// Register reset values.
	localparam logic        RST_COLOR_MODE       = 1'b0;
	localparam logic [11:0] RST_FRAME_WIDTH      = 12'd2048;
	localparam logic [15:0] RST_FRAME_HEIGHT     = 16'd1;
	localparam logic [23:0] RST_BACKGROUND_COLOR = 24'h192330;
	localparam logic [23:0] RST_BOUNDARY_COLOR   = 24'h141414;

	// Colour modes.
	localparam logic MODE_HASH  = 1'b0;
	localparam logic MODE_BLEND = 1'b1;

	// Hash colouring: only the low 23 bits of the product are ever used.
	localparam logic [31:0] HASH_MUL   = 32'd2654435761;
	localparam int          HASH_LO_W  = 23;
	localparam logic [7:0]  HASH_BASE  = 8'd50;
	localparam logic [6:0]  HASH_MASK  = 7'h7F;
	localparam logic [7:0]  BLEND_FULL = 8'd255;

	typedef struct packed {
		logic        color_mode;
		logic [11:0] frame_width;
		logic [15:0] frame_height;
		logic [23:0] background_color;
		logic [23:0] boundary_color;
	} cfg_t;

	// How the emitted pixel is coloured.
	typedef enum logic [1:0] {
		KIND_BACKGROUND,
		KIND_BOUNDARY,
		KIND_HASH,
		KIND_BLEND
	} kind_t;

	// Per-pixel control carried from the input into the colour pipeline.
	typedef struct packed {
		logic [15:0] label;      // label below the emitted pixel (0 in a flush row)
		logic        emit;       // a pixel of the previous row is produced
		logic        frame_end;  // that pixel closes the frame
		logic        right_ok;   // right neighbour lies inside the row
		logic        up_ok;      // the row above the emitted pixel exists
		logic        col0;       // first column: left neighbour is outside
		logic        fwd;        // prefetched column 0 is being written this beat
	} item_t;

endpackage

// ===== rtl/core/region_boundary_colorizer_core.sv =====
// ----------------------------------------------------------------------------
// region_boundary_colorizer_core
// Colours a raster stream of region labels one row behind the input: label
// zero takes the background colour, region edges the boundary colour and the
// interior a hashed colour or the overlay blended over the background.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle, sustained, on both streams while m_tready is held high.
// Path: the result of an accepted input beat reaches m_tdata through the line
// buffer read register, the product stage and the output register.
// The rate is set by the label line buffer: two reads and one write per beat.
// Reset clears the position counters, the pipeline and the registers at once;
// the line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module region_boundary_colorizer_core #(
	parameter int MAX_WIDTH = rbc_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rbc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rbc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rbc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// region_label[15:0], overlay_red[23:16], overlay_green[31:24],
	// overlay_blue[39:32], overlay_alpha[47:40]
	input  logic [47:0]                    s_tdata,
	// drain[0]
	input  logic [0:0]                     s_tuser,
	// Output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic [23:0]                    m_tdata,
	output logic                           m_tlast
);

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int LADDR_W = COL_W + 1;
	localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W   = (WCNT_W > 12) ? WCNT_W : 12;

	rbc_pkg::cfg_t  cfg;
	rbc_pkg::item_t item;

	// Position of the next input beat.
	logic [COL_W-1:0] col_q;
	logic [15:0]      row_q;

	logic [CMP_W-1:0]  fw_ext;
	logic [CMP_W-1:0]  w_ext;
	logic [WCNT_W-1:0] eff_w;
	logic [15:0]       eff_h;
	logic [WCNT_W-1:0] col_inc;
	logic              wrap, flush, drain, accept, take, wr_en, pipe_ready;
	logic [15:0]       label_in;
	logic [31:0]       overlay_in;
	logic [LADDR_W-1:0] a_addr, b_addr;
	logic [15:0]       a_data, b_data;
	logic [31:0]       ov_data;

	rbc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Effective frame size: a width of zero acts as one and widths beyond the
	// line buffer saturate; a height of zero acts as one.
	assign fw_ext = CMP_W'(cfg.frame_width);
	always_comb begin
		if (fw_ext == '0) begin
			w_ext = CMP_W'(1);
		end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
			w_ext = CMP_W'(MAX_WIDTH);
		end else begin
			w_ext = fw_ext;
		end
	end
	assign eff_w = w_ext[WCNT_W-1:0];
	assign eff_h = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;

	assign col_inc = WCNT_W'(col_q) + WCNT_W'(1);
	assign wrap    = col_inc >= eff_w;
	// Rows at or past the frame height only flush the last real row.
	assign flush   = row_q >= eff_h;
	assign drain   = s_tuser[0];

	// A drain beat before the flush row is taken off the bus and dropped.
	assign s_tready = pipe_ready;
	assign accept   = s_tvalid && s_tready;
	assign take     = accept && !(drain && !flush);
	assign wr_en    = take && !flush;

	assign label_in   = flush ? 16'd0 : s_tdata[15:0];
	assign overlay_in = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]};

	// Port b reads the row above the emitted pixel at this column (same bank
	// as the row now arriving) and takes the new label in the same beat.
	// Port a reads the right neighbour in the previous row; that value becomes
	// the centre label of the next beat. On the last beat of a row there is no
	// right neighbour, so port a prefetches column 0 of the row being written,
	// which is the centre label of the first beat of the next row.
	assign b_addr = {row_q[0], col_q};
	assign a_addr = wrap ? {row_q[0], COL_W'(0)} : {~row_q[0], col_inc[COL_W-1:0]};

	always_comb begin
		item.label     = label_in;
		item.emit      = row_q != 16'd0;
		item.frame_end = (row_q == eff_h) && (col_inc == eff_w);
		item.right_ok  = !wrap;
		item.up_ok     = row_q >= 16'd2;
		item.col0      = col_q == '0;
		// With a one-pixel row the prefetch hits the entry written in the
		// same beat, so the new label is forwarded instead.
		item.fwd       = wrap && !flush && (col_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= flush ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	rbc_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_store (
		.clk        (clk),
		.take       (take),
		.wr_en      (wr_en),
		.a_addr     (a_addr),
		.b_addr     (b_addr),
		.col        (col_q),
		.wr_label   (label_in),
		.wr_overlay (overlay_in),
		.a_data     (a_data),
		.b_data     (b_data),
		.ov_data    (ov_data)
	);

	rbc_color_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.a_data   (a_data),
		.b_data   (b_data),
		.ov_data  (ov_data),
		.cfg      (cfg),
		.ready    (pipe_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/core/rbc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rbc_cfg_regs
// APB register bank holding the colouriser configuration.
// ----------------------------------------------------------------------------
module rbc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rbc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rbc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rbc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output rbc_pkg::cfg_t                     cfg
);

	rbc_pkg::cfg_t    cfg_q;
	rbc_pkg::reg_idx_t idx;
	logic             wr;

	assign pready = 1'b1;
	assign idx    = rbc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode       <= rbc_pkg::RST_COLOR_MODE;
			cfg_q.frame_width      <= rbc_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height     <= rbc_pkg::RST_FRAME_HEIGHT;
			cfg_q.background_color <= rbc_pkg::RST_BACKGROUND_COLOR;
			cfg_q.boundary_color   <= rbc_pkg::RST_BOUNDARY_COLOR;
		end else if (wr) begin
			case (idx)
				rbc_pkg::REG_COLOR_MODE:       cfg_q.color_mode       <= pwdata[0];
				rbc_pkg::REG_FRAME_WIDTH:      cfg_q.frame_width      <= pwdata[11:0];
				rbc_pkg::REG_FRAME_HEIGHT:     cfg_q.frame_height     <= pwdata[15:0];
				rbc_pkg::REG_BACKGROUND_COLOR: cfg_q.background_color <= pwdata[23:0];
				rbc_pkg::REG_BOUNDARY_COLOR:   cfg_q.boundary_color   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rbc_pkg::REG_COLOR_MODE:       prdata = {31'd0, cfg_q.color_mode};
			rbc_pkg::REG_FRAME_WIDTH:      prdata = {20'd0, cfg_q.frame_width};
			rbc_pkg::REG_FRAME_HEIGHT:     prdata = {16'd0, cfg_q.frame_height};
			rbc_pkg::REG_BACKGROUND_COLOR: prdata = {8'd0, cfg_q.background_color};
			rbc_pkg::REG_BOUNDARY_COLOR:   prdata = {8'd0, cfg_q.boundary_color};
			default:                       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/rbc_line_store.sv =====
// ----------------------------------------------------------------------------
// rbc_line_store
// Label line buffers (two banks by row parity) and the overlay line buffer,
// with registered read data.
// ----------------------------------------------------------------------------
module rbc_line_store #(
	parameter int MAX_WIDTH = rbc_pkg::DEF_MAX_WIDTH,
	localparam int COL_W    = $clog2(MAX_WIDTH),
	localparam int LADDR_W  = COL_W + 1
) (
	input  logic               clk,
	input  logic               take,
	input  logic               wr_en,
	input  logic [LADDR_W-1:0] a_addr,
	input  logic [LADDR_W-1:0] b_addr,
	input  logic [COL_W-1:0]   col,
	input  logic [15:0]        wr_label,
	input  logic [31:0]        wr_overlay,
	output logic [15:0]        a_data,
	output logic [15:0]        b_data,
	output logic [31:0]        ov_data
);

	// The bank bit sits above the column, so the label store spans the whole
	// address range even when the width is not a power of two.
	logic [15:0] label_mem [2**LADDR_W];
	logic [31:0] ovl_mem   [MAX_WIDTH];
	logic [15:0] a_data_q;
	logic [15:0] b_data_q;
	logic [31:0] ov_data_q;

	// Reads return the old contents when the same entry is written in the
	// same beat; the label write always goes to the b port address.
	always_ff @(posedge clk) begin
		if (take) begin
			a_data_q  <= label_mem[a_addr];
			b_data_q  <= label_mem[b_addr];
			ov_data_q <= ovl_mem[col];
			if (wr_en) begin
				label_mem[b_addr] <= wr_label;
				ovl_mem[col]      <= wr_overlay;
			end
		end
	end

	assign a_data  = a_data_q;
	assign b_data  = b_data_q;
	assign ov_data = ov_data_q;

endmodule

// ===== rtl/core/rbc_color_pipe.sv =====
// ----------------------------------------------------------------------------
// rbc_color_pipe
// Neighbour compare, hash and blend products, colour selection and the
// output register of the colouriser.
// ----------------------------------------------------------------------------
module rbc_color_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  rbc_pkg::item_t item,
	input  logic [15:0]    a_data,
	input  logic [15:0]    b_data,
	input  logic [31:0]    ov_data,
	input  rbc_pkg::cfg_t  cfg,
	output logic           ready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [23:0]    m_tdata,
	output logic           m_tlast
);

	// Stage 1: line buffer data is valid.
	logic           valid_s1;
	rbc_pkg::item_t item_s1;
	logic [15:0]    next_self_q;
	logic [15:0]    left_q;

	// Stage 2: products registered.
	logic                              valid_s2;
	logic                              emit_s2;
	logic                              fend_s2;
	rbc_pkg::kind_t                    kind_s2;
	logic [rbc_pkg::HASH_LO_W-1:0]     hash_s2;
	logic [15:0]                       prod_s2 [3];

	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic        m_tlast_q;

	logic out_free, s2_go, s2_free, s1_go;

	logic [15:0]    self_lab, left_lab, right_lab, up_lab, down_lab, next_self;
	rbc_pkg::kind_t kind;
	logic [38:0]    hash_prod;
	logic [15:0]    prod [3];
	logic [16:0]    psum [3];
	logic [7:0]     fg [3];
	logic [7:0]     bg [3];
	logic [7:0]     alpha, inv_alpha;
	logic [16:0]    qt [3];
	logic [7:0]     blend [3];
	logic [23:0]    color;

	assign out_free = !m_tvalid_q || m_tready;
	assign s2_go    = valid_s2 && (out_free || !emit_s2);
	assign s2_free  = !valid_s2 || s2_go;
	assign s1_go    = valid_s1 && s2_free;
	assign ready    = !valid_s1 || s2_free;

	// Neighbours of the pixel being emitted.
	assign self_lab  = next_self_q;
	assign left_lab  = item_s1.col0 ? 16'd0 : left_q;
	assign right_lab = item_s1.right_ok ? a_data : 16'd0;
	assign up_lab    = item_s1.up_ok ? b_data : 16'd0;
	assign down_lab  = item_s1.label;
	assign next_self = item_s1.fwd ? item_s1.label : a_data;

	always_comb begin
		if (self_lab == 16'd0) begin
			kind = rbc_pkg::KIND_BACKGROUND;
		end else if (left_lab != self_lab || right_lab != self_lab ||
			up_lab != self_lab || down_lab != self_lab) begin
			kind = rbc_pkg::KIND_BOUNDARY;
		end else if (cfg.color_mode == rbc_pkg::MODE_HASH) begin
			kind = rbc_pkg::KIND_HASH;
		end else begin
			kind = rbc_pkg::KIND_BLEND;
		end
	end

	assign hash_prod = {23'd0, self_lab} *
		{16'd0, rbc_pkg::HASH_MUL[rbc_pkg::HASH_LO_W-1:0]};

	assign alpha     = ov_data[7:0];
	assign inv_alpha = rbc_pkg::BLEND_FULL - alpha;
	assign fg[0]     = ov_data[31:24];
	assign fg[1]     = ov_data[23:16];
	assign fg[2]     = ov_data[15:8];
	assign bg[0]     = cfg.background_color[23:16];
	assign bg[1]     = cfg.background_color[15:8];
	assign bg[2]     = cfg.background_color[7:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum[i] = {1'b0, {8'd0, fg[i]} * {8'd0, alpha}} +
				{1'b0, {8'd0, bg[i]} * {8'd0, inv_alpha}};
			prod[i] = psum[i][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready) begin
				valid_s1 <= take;
			end
			if (s2_free) begin
				valid_s2 <= s1_go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (s1_go) begin
			next_self_q <= next_self;
			left_q      <= self_lab;
			emit_s2     <= item_s1.emit;
			fend_s2     <= item_s1.frame_end;
			kind_s2     <= kind;
			hash_s2     <= hash_prod[rbc_pkg::HASH_LO_W-1:0];
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= prod[i];
			end
		end
	end

	// Division by 255 through the usual reciprocal form; exact below 65280.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qt[i]    = {1'b0, prod_s2[i]} + 17'd1 + {9'd0, prod_s2[i][15:8]};
			blend[i] = qt[i][15:8];
		end
	end

	always_comb begin
		case (kind_s2)
			rbc_pkg::KIND_BACKGROUND: color = cfg.background_color;
			rbc_pkg::KIND_BOUNDARY:   color = cfg.boundary_color;
			rbc_pkg::KIND_HASH: begin
				color = {rbc_pkg::HASH_BASE + {1'b0, hash_s2[6:0] & rbc_pkg::HASH_MASK},
					rbc_pkg::HASH_BASE + {1'b0, hash_s2[14:8] & rbc_pkg::HASH_MASK},
					rbc_pkg::HASH_BASE + {1'b0, hash_s2[22:16] & rbc_pkg::HASH_MASK}};
			end
			rbc_pkg::KIND_BLEND:      color = {blend[0], blend[1], blend[2]};
			default:                  color = cfg.background_color;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			m_tdata_q <= {color[7:0], color[15:8], color[23:16]};
			m_tlast_q <= fend_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== tb/region_boundary_colorizer_core_tb.sv =====
// ----------------------------------------------------------------------------
// region_boundary_colorizer_core_tb
// Self-checking bench for the region boundary colouriser. Raster frames of
// labels and overlay pixels are streamed in, an in-bench predictor works out
// each output pixel one row behind, and every output beat is compared field
// by field with the oldest prediction. Directed frames cover the reset
// register values, both colour modes and the degenerate sizes; random frames
// with coherent regions make up the bulk of the run.
// ----------------------------------------------------------------------------
module region_boundary_colorizer_core_tb;

	localparam int MAX_W = rbc_pkg::DEF_MAX_WIDTH;

	// Results trail accepted beats through the core's pipeline registers; give the
	// core a comfortable margin before touching the registers or ending the run.
	localparam int SETTLE_CYCLES = 8;

	// Number of pixel and flush beats in the random part.
	localparam int RANDOM_BEATS = 620;

	// Size of the frame run with the registers mostly at their reset values.
	localparam int DEF_TEST_W = 24;
	localparam int DEF_TEST_H = 5;

	// Height of the narrow frame that walks the row counter.
	localparam int TALL_H = 250;

	// Mismatch lines printed before the bench goes quiet (all are counted).
	localparam int PRINT_CAP = 100;

	// Overlay pixel as carried in s_tdata above the label.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} overlay_t;

	// One predicted output beat.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} pixel_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                           psel    = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite  = 1'b0;
	logic [rbc_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [rbc_pkg::APB_DATA_W-1:0] pwdata  = '0;
	logic [rbc_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;

	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	// When set, neither the sender nor the receiver inserts idle cycles.
	bit no_gaps = 1'b0;

	int unsigned mismatches  = 0;
	int unsigned pixels_seen = 0;

	// Shadow copy of the register file, updated on each APB write.
	logic        cfg_mode   = rbc_pkg::RST_COLOR_MODE;
	logic [11:0] cfg_width  = rbc_pkg::RST_FRAME_WIDTH;
	logic [15:0] cfg_height = rbc_pkg::RST_FRAME_HEIGHT;
	logic [23:0] cfg_bg     = rbc_pkg::RST_BACKGROUND_COLOR;
	logic [23:0] cfg_bnd    = rbc_pkg::RST_BOUNDARY_COLOR;

	// Predictor state: two label lines (one per row parity), the overlay of
	// the previous row and the position of the next input beat.
	logic [15:0] line_labels [2*MAX_W];
	overlay_t    line_overlay [MAX_W];
	int unsigned next_col = 0;
	int unsigned next_row = 0;

	// Output pixels still owed by the core, oldest first.
	pixel_t expected_pixels [$];
	pixel_t want_pixel;

	region_boundary_colorizer_core #(
		.MAX_WIDTH(MAX_W)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a run that has not finished by this time is declared a
	// hang.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver back-pressure: unless gaps are off, m_tready drops at random with a probability of 13 percent.
	always @(posedge clk) begin
		m_tready <= no_gaps || ($urandom_range(99) >= 13);
	end

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP) begin
			$display("pixel %0d: %s is %0h, expected %0h", pixels_seen, what, got, want);
		end
		mismatches++;
	endtask

	// Every accepted output beat is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				flag_mismatch("beat with nothing owed, data", 32'(m_tdata), '0);
			end else begin
				want_pixel = expected_pixels.pop_front();
				if (m_tdata[7:0] !== want_pixel.red) begin
					flag_mismatch("out_red", 32'(m_tdata[7:0]), 32'(want_pixel.red));
				end
				if (m_tdata[15:8] !== want_pixel.green) begin
					flag_mismatch("out_green", 32'(m_tdata[15:8]), 32'(want_pixel.green));
				end
				if (m_tdata[23:16] !== want_pixel.blue) begin
					flag_mismatch("out_blue", 32'(m_tdata[23:16]), 32'(want_pixel.blue));
				end
				if (m_tlast !== want_pixel.frame_end) begin
					flag_mismatch("frame_end", 32'(m_tlast), 32'(want_pixel.frame_end));
				end
			end
			pixels_seen++;
		end
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	function automatic logic [15:0] label_at(input int unsigned row, input int unsigned col);
		return line_labels[(row % 2) * MAX_W + col];
	endfunction

	// Alpha blend of one channel, dividing by 255 and truncating.
	function automatic logic [7:0] mix_channel(input logic [7:0] fg, input logic [7:0] bg,
			input logic [7:0] a);
		int unsigned acc;
		acc = int'(fg) * int'(a) + int'(bg) * (255 - int'(a));
		return 8'(acc / 255);
	endfunction

	// Takes one accepted input beat and queues the pixel it releases, if any.
	// The pixel released is the one directly above the arriving position; its
	// neighbours are the two label lines plus the arriving label below it.
	task automatic predict_pixel(input logic [15:0] lab_in, input overlay_t ov_in,
			input logic drn);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		logic        flush;
		logic [15:0] lab;
		logic [15:0] mid;
		logic [15:0] lft;
		logic [15:0] rgt;
		logic [15:0] abv;
		overlay_t    ov;
		overlay_t    under;
		logic [31:0] hv;
		logic [23:0] colour;
		pixel_t      px;

		// Width 0 acts as 1 and anything past the line buffer saturates;
		// height 0 acts as 1.
		w = (cfg_width == 12'd0) ? 1 :
			((32'(cfg_width) > MAX_W) ? MAX_W : 32'(cfg_width));
		h = (cfg_height == 16'd0) ? 1 : 32'(cfg_height);
		c = next_col;
		r = next_row;
		flush = (r >= h);

		// A drain beat before the flush row is swallowed without advancing.
		if (drn && !flush) return;

		// Flush-row beats stand for label 0 below the last row.
		lab = flush ? '0 : lab_in;
		ov  = flush ? '0 : ov_in;

		if (r >= 1) begin
			mid = label_at(r - 1, c);
			lft = '0;
			rgt = '0;
			abv = '0;
			if (c >= 1) lft = label_at(r - 1, c - 1);
			if (c + 1 < w) rgt = label_at(r - 1, c + 1);
			if (r >= 2) abv = label_at(r, c);

			if (mid == 0) begin
				colour = cfg_bg;
			end else if (lft != mid || rgt != mid || abv != mid || lab != mid) begin
				colour = cfg_bnd;
			end else if (cfg_mode == rbc_pkg::MODE_HASH) begin
				hv = 32'(mid) * rbc_pkg::HASH_MUL;
				colour = {rbc_pkg::HASH_BASE + 8'(hv[6:0]), rbc_pkg::HASH_BASE + 8'(hv[14:8]),
					rbc_pkg::HASH_BASE + 8'(hv[22:16])};
			end else begin
				under = line_overlay[c];
				colour = {mix_channel(under.red, cfg_bg[23:16], under.alpha),
					mix_channel(under.green, cfg_bg[15:8], under.alpha),
					mix_channel(under.blue, cfg_bg[7:0], under.alpha)};
			end

			px.red       = colour[23:16];
			px.green     = colour[15:8];
			px.blue      = colour[7:0];
			px.frame_end = (r - 1 == h - 1) && (c == w - 1);
			expected_pixels.push_back(px);
		end

		if (!flush) begin
			line_labels[(r % 2) * MAX_W + c] = lab;
			line_overlay[c] = ov;
		end

		if (c + 1 >= w) begin
			next_col = 0;
			next_row = flush ? 0 : ((r + 1) & 32'hFFFFF);
		end else begin
			next_col = c + 1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offers one beat, with random idle cycles in front unless gaps are off,
	// and predicts its effect once the core has taken it.
	task automatic send_beat(input logic [15:0] lab, input overlay_t ov, input logic drn);
		while (!no_gaps && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ov.alpha, ov.blue, ov.green, ov.red, lab};
		s_tuser  <= drn;
		do @(posedge clk); while (!s_tready);
		predict_pixel(lab, ov, drn);
	endtask

	// Stops the sender and waits for every owed pixel, then lets the
	// pipeline settle, since row-0 beats may still be in flight.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB write: setup then access phase. psel is left high so that
	// writes can follow back to back; the caller drops it afterwards.
	task automatic apb_write(input rbc_pkg::reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rbc_pkg::REG_COLOR_MODE:       cfg_mode   = value[0];
			rbc_pkg::REG_FRAME_WIDTH:      cfg_width  = value[11:0];
			rbc_pkg::REG_FRAME_HEIGHT:     cfg_height = value[15:0];
			rbc_pkg::REG_BACKGROUND_COLOR: cfg_bg     = value[23:0];
			rbc_pkg::REG_BOUNDARY_COLOR:   cfg_bnd    = value[23:0];
			default: ;
		endcase
	endtask

	// Returns the APB port to idle after a run of writes.
	task automatic apb_idle();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Rewrites the whole register file once the core has gone quiet.
	task automatic configure(input logic mode, input int unsigned width,
			input int unsigned height, input logic [23:0] bg, input logic [23:0] bnd);
		wait_idle();
		apb_write(rbc_pkg::REG_COLOR_MODE, 32'(mode));
		apb_write(rbc_pkg::REG_FRAME_WIDTH, 32'(width));
		apb_write(rbc_pkg::REG_FRAME_HEIGHT, 32'(height));
		apb_write(rbc_pkg::REG_BACKGROUND_COLOR, 32'(bg));
		apb_write(rbc_pkg::REG_BOUNDARY_COLOR, 32'(bnd));
		apb_idle();
	endtask

	// ------------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------------

	function automatic logic [7:0] random_alpha();
		int unsigned roll;
		roll = $urandom_range(7);
		if (roll == 0) return 8'h00;
		if (roll == 1) return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic overlay_t random_overlay();
		overlay_t ov;
		ov = overlay_t'($urandom);
		ov.alpha = random_alpha();
		return ov;
	endfunction

	function automatic logic [23:0] random_colour();
		int unsigned roll;
		roll = $urandom_range(7);
		if (roll == 0) return 24'h000000;
		if (roll == 1) return 24'hFFFFFF;
		return 24'($urandom);
	endfunction

	// Mostly continues the region above or to the left, so that frames hold
	// real interiors; otherwise a fresh label, often 0 or the top value.
	function automatic logic [15:0] pick_label(input logic [15:0] above,
			input logic [15:0] left, input bit has_above, input bit has_left);
		int unsigned roll;
		roll = $urandom_range(99);
		if (has_above && roll < 55) return above;
		if (has_left && roll < 80) return left;
		roll = $urandom_range(99);
		if (roll < 20) return 16'h0000;
		if (roll < 30) return 16'hFFFF;
		if (roll < 45) return 16'($urandom);
		return 16'($urandom_range(1, 5));
	endfunction

	// The flush row that closes a frame: mostly drain beats, but now and then
	// a pixel beat, which the core must treat just the same.
	task automatic send_flush_row(input int unsigned width);
		int unsigned c;
		for (c = 0; c < width; c++) begin
			send_beat(16'($urandom), random_overlay(), $urandom_range(9) != 0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Colour mode and both colours left at their reset values; only the frame
	// size is written. A drain under the reset registers must be ignored.
	// Run with no idling on either side.
	task automatic test_reset_defaults();
		logic [15:0] row_above [DEF_TEST_W];
		logic [15:0] lab;
		int unsigned r;
		int unsigned c;

		no_gaps = 1'b1;
		send_beat(16'($urandom), random_overlay(), 1'b1);
		wait_idle();
		apb_write(rbc_pkg::REG_FRAME_WIDTH, 32'(DEF_TEST_W));
		apb_write(rbc_pkg::REG_FRAME_HEIGHT, 32'(DEF_TEST_H));
		apb_idle();
		lab = '0;
		for (r = 0; r < DEF_TEST_H; r++) begin
			for (c = 0; c < DEF_TEST_W; c++) begin
				lab = pick_label(row_above[c], lab, r > 0, c > 0);
				send_beat(lab, random_overlay(), 1'b0);
				row_above[c] = lab;
			end
		end
		send_flush_row(DEF_TEST_W);
		wait_idle();
		no_gaps = 1'b0;
	endtask

	// Two hand-built frames: a 3x3 hash frame with one interior pixel of the
	// top label, and a 4x3 blend frame whose two interior pixels carry fully
	// transparent and fully opaque overlays.
	task automatic test_directed_frames();
		int unsigned r;
		int unsigned c;
		logic [15:0] lab;
		overlay_t    ov;

		configure(rbc_pkg::MODE_HASH, 3, 3, 24'h000000, 24'hFFFFFF);
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				// A drain in mid-frame must be ignored.
				if (r == 1 && c == 0) send_beat(16'hFFFF, '1, 1'b1);
				if (r == 0 && c == 0) lab = 16'h0000;
				else if (r == 2 && c == 2) lab = 16'h0001;
				else lab = 16'hFFFF;
				ov = ((r + c) % 2 != 0) ? '1 : '0;
				send_beat(lab, ov, 1'b0);
			end
		end
		send_flush_row(3);

		configure(rbc_pkg::MODE_BLEND, 4, 3, 24'hFFFFFF, 24'h000000);
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 4; c++) begin
				if (r == 1 && c == 1) ov = '{8'hFF, 8'h00, 8'h80, 8'h00};
				else if (r == 1 && c == 2) ov = '{8'h12, 8'h34, 8'h56, 8'hFF};
				else ov = random_overlay();
				send_beat(16'h0001, ov, 1'b0);
			end
		end
		send_flush_row(4);
	endtask

	// Width and height of zero (acting as one) and a single column.
	task automatic test_degenerate_sizes();
		int unsigned r;

		configure(1'($urandom_range(1)), 0, 0, random_colour(), random_colour());
		send_beat(16'($urandom), random_overlay(), 1'b0);
		send_flush_row(1);

		configure(rbc_pkg::MODE_BLEND, 1, 3, random_colour(), random_colour());
		for (r = 0; r < 3; r++) begin
			send_beat(pick_label('0, '0, 1'b0, 1'b0), random_overlay(), 1'b0);
		end
		send_flush_row(1);
	endtask

	// A tall frame, one pixel wide, to walk the row counter and the bank
	// parity through many rows.
	task automatic test_tall_frame();
		int unsigned r;
		logic [15:0] lab;

		configure(1'($urandom_range(1)), 1, TALL_H, random_colour(), random_colour());
		lab = '0;
		for (r = 0; r < TALL_H; r++) begin
			lab = pick_label(lab, '0, r > 0, 1'b0);
			send_beat(lab, random_overlay(), 1'b0);
		end
		send_flush_row(1);
	endtask

	// Random frames, mostly small, with coherent regions, the odd stray drain
	// in mid-frame, and a fresh register setting for every frame. Once, the
	// sender stops in mid-frame until every owed pixel has come out.
	task automatic test_random_frames();
		logic [15:0] row_above [MAX_W];
		logic [15:0] lab;
		int unsigned beats;
		int unsigned rem;
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		bit          paused;

		beats  = 0;
		paused = 1'b0;
		lab    = '0;
		while (beats < RANDOM_BEATS) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(13, 96) : $urandom_range(1, 12);
			h = (beats == 0) ? $urandom_range(2, 8) : $urandom_range(1, 8);
			// Keep the last frame within the beat budget.
			rem = RANDOM_BEATS - beats;
			while (h > 1 && w * (h + 1) > rem) h--;
			if (w * (h + 1) > rem) w = (rem >= 2) ? rem / 2 : 1;
			configure(1'($urandom_range(1)), w, h, random_colour(), random_colour());
			for (r = 0; r < h; r++) begin
				for (c = 0; c < w; c++) begin
					if ($urandom_range(99) < 4) begin
						send_beat(16'($urandom), random_overlay(), 1'b1);
					end
					lab = pick_label(row_above[c], lab, r > 0, c > 0);
					send_beat(lab, random_overlay(), 1'b0);
					row_above[c] = lab;
					beats++;
					if (!paused && r >= 1) begin
						wait_idle();
						paused = 1'b1;
					end
				end
			end
			send_flush_row(w);
			beats += w;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_frames();
		test_degenerate_sizes();
		test_tall_frame();
		test_random_frames();

		// Everything sent: wait for the last pixels and a quiet pipeline.
		wait_idle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
